>>> hw/rtl/gjt_pkg.sv
// ----------------------------------------------------------------------------
// gjt_pkg
// Shared constants, register codes and the divider step for the glyph jitter
// transform pipeline.
// ----------------------------------------------------------------------------
package gjt_pkg;

    // hash constants
    localparam logic [31:0] HASH_PX  = 32'd374761393;
    localparam logic [31:0] HASH_MIX = 32'd1274126177;
    // y = 5 term of the second hash, 5 * 668265263 mod 2^32
    localparam logic [31:0] HASH_Y5  = 32'd3341326315;

    // fixed-point gains
    localparam logic [13:0] K_SHAKE  = 14'd12902;  // 12.6 in Q.10
    localparam logic [13:0] K_TREMOR = 14'd4516;   // 4.41 in Q.10
    localparam logic [10:0] K_SIZE   = 11'd1638;   // 0.025 in Q.16
    localparam logic [12:0] K_VEL    = 13'd7864;   // 0.12 in Q.16

    localparam logic [15:0] W_LO     = 16'd8192;   // 0.5 in Q2.14
    localparam logic [15:0] W_HI     = 16'd32768;  // 2.0 in Q2.14

    typedef enum logic [2:0] {
        CFG_SEED     = 3'd0,
        CFG_SHAKE    = 3'd1,
        CFG_TREMOR   = 3'd2,
        CFG_SIZE     = 3'd3,
        CFG_VEL_EN   = 3'd4,
        CFG_PRESSURE = 3'd5,
        CFG_BASE     = 3'd6
    } t_cfg_idx;

    // restoring divider state: partial remainder and quotient bits so far
    typedef struct packed {
        logic [16:0] rem;
        logic [14:0] quo;
    } t_div;

    function automatic t_div div_step(t_div d, logic [15:0] bs, logic shift);
        t_div        r;
        logic [16:0] x;
        x     = shift ? {d.rem[15:0], 1'b0} : d.rem;
        r.quo = {d.quo[13:0], 1'b0};
        if (x >= {1'b0, bs}) begin
            r.rem    = x - {1'b0, bs};
            r.quo[0] = 1'b1;
        end else begin
            r.rem = x;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/glyph_jitter_transform_top.sv
// ----------------------------------------------------------------------------
// glyph_jitter_transform_top
// Per-cluster jitter, tremor, size and alpha transform, eight-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one cluster beat per clock while the output side does not stall and
// returns one transform beat per cluster from the output register. Each
// stage has its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up and a stalled output register holds its
// beat while earlier stages keep filling. The latency is set by the hash
// multipliers, the width / base_size division (15 restoring steps spread over
// four stages) and the two-multiply pressure chain feeding alpha.
// Configuration writes take effect for later beats and reach beats in flight.
module glyph_jitter_transform_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    // cluster input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] cluster_index, [31:16] cluster_width
    // transform output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [15:0] offset_x, [31:16] offset_y,
                                        // [47:32] size_scale, [55:48] alpha
);
    import gjt_pkg::*;

    localparam int STAGES = 8;

    // config registers
    logic [31:0] r_seed;
    logic [15:0] r_shake, r_tremor, r_size, r_pressure, r_base;
    logic        r_vel_en;
    // derived gains
    logic [29:0] r_gx, r_gy;
    logic [26:0] r_gs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_shake    <= '0;
            r_tremor   <= '0;
            r_size     <= '0;
            r_vel_en   <= 1'b0;
            r_pressure <= '0;
            r_base     <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SEED:     r_seed     <= i_cfg_data;
                CFG_SHAKE:    r_shake    <= i_cfg_data[15:0];
                CFG_TREMOR:   r_tremor   <= i_cfg_data[15:0];
                CFG_SIZE:     r_size     <= i_cfg_data[15:0];
                CFG_VEL_EN:   r_vel_en   <= i_cfg_data[0];
                CFG_PRESSURE: r_pressure <= i_cfg_data[15:0];
                CFG_BASE:     r_base     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_gx <= 30'(r_tremor * K_TREMOR);
        r_gy <= 30'(r_shake * K_SHAKE);
        r_gs <= 27'(r_size * K_SIZE);
    end

    // stage handshake
    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] w_en;
    logic [STAGES-1:0] w_en_up;

    always_comb begin
        w_en[STAGES-1] = !r_v[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
        w_en_up = {m_axis_tready, w_en[STAGES-1:1]};
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: hash premix, divider steps 1-4
    logic [15:0] w_idx, w_cw;
    logic [31:0] w_a1, w_a2;
    t_div        w_d0;
    logic        w_sat0;
    logic [31:0] r_a1, r_a2;
    t_div        r_d0;
    logic        r_sat0;

    assign w_idx = s_axis_tdata[15:0];
    assign w_cw  = s_axis_tdata[31:16];

    always_comb begin
        w_a1   = 32'(w_idx) * 32'd3 * HASH_PX + r_seed;
        w_a2   = 32'(w_idx) * 32'd7 * HASH_PX + HASH_Y5 + r_seed;
        // width >= 2 * base_size (or base_size zero) clamps w to 2.0
        w_sat0 = {1'b0, w_cw} >= {r_base, 1'b0};
        w_d0   = '{rem: {1'b0, w_cw}, quo: '0};
        for (int j = 0; j < 4; j++) begin
            w_d0 = div_step(w_d0, r_base, 1'(j != 0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a1   <= w_a1;
            r_a2   <= w_a2;
            r_d0   <= w_d0;
            r_sat0 <= w_sat0;
        end
    end

    // stage 1: hash multiply, divider steps 5-8
    logic [31:0] r_b1, r_b2;
    t_div        w_d1, r_d1;
    logic        r_sat1;

    always_comb begin
        w_d1 = r_d0;
        for (int j = 0; j < 4; j++) begin
            w_d1 = div_step(w_d1, r_base, 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_b1   <= (r_a1 ^ (r_a1 >> 13)) * HASH_MIX;
            r_b2   <= (r_a2 ^ (r_a2 >> 13)) * HASH_MIX;
            r_d1   <= w_d1;
            r_sat1 <= r_sat0;
        end
    end

    // stage 2: hash finish, divider steps 9-12
    logic [31:0] w_c1, w_c2;
    logic [30:0] r_h1, r_h2;
    t_div        w_d2, r_d2;
    logic        r_sat2;

    always_comb begin
        w_c1 = r_b1 ^ (r_b1 >> 16);
        w_c2 = r_b2 ^ (r_b2 >> 16);
        w_d2 = r_d1;
        for (int j = 0; j < 4; j++) begin
            w_d2 = div_step(w_d2, r_base, 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_h1   <= w_c1[30:0];
            r_h2   <= w_c2[30:0];
            r_d2   <= w_d2;
            r_sat2 <= r_sat1;
        end
    end

    // stage 3: noise products, pressure term, divider steps 13-15
    logic signed [31:0] w_n1, w_n2, w_gx, w_gy, w_gs;
    logic signed [63:0] r_px, r_py, r_ps;
    logic [47:0]        r_pr;
    t_div               w_d3;
    logic [14:0]        r_q3;
    logic               r_sat3;

    always_comb begin
        w_n1 = signed'({1'b0, r_h1}) - 32'sd1073741824;
        w_n2 = signed'({1'b0, r_h2}) - 32'sd1073741824;
        w_gx = signed'({2'b0, r_gx});
        w_gy = signed'({2'b0, r_gy});
        w_gs = signed'({5'b0, r_gs});
        w_d3 = r_d2;
        for (int j = 0; j < 3; j++) begin
            w_d3 = div_step(w_d3, r_base, 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_px   <= w_n2 * w_gx;
            r_py   <= w_n1 * w_gy;
            r_ps   <= w_n2 * w_gs;
            r_pr   <= (48'd1 << 44) + 48'(r_h1) * 48'(r_pressure);
            r_q3   <= w_d3.quo;
            r_sat3 <= r_sat2;
        end
    end

    // stage 4: round offsets and size, velocity term
    // |product| < 2^60, so rounded offsets stay within +-2^14 and size within
    // 1.0 +- 2^11: the saturation bounds are never reached
    localparam logic signed [63:0] RND46 = 64'sd35184372088832;
    logic signed [63:0] w_rx, w_ry, w_rs;
    logic [15:0]        w_w, w_wc;
    logic [14:0]        w_dw;
    logic [15:0]        r_ox4, r_oy4, r_ss4;
    logic [32:0]        r_p30_4;
    logic [27:0]        r_sub4;

    always_comb begin
        w_rx = r_px + RND46;
        w_ry = r_py + RND46;
        w_rs = r_ps + RND46;
        w_w  = r_sat3 ? W_HI : {1'b0, r_q3};
        w_wc = (w_w < W_LO) ? W_LO : w_w;
        w_dw = 15'(w_wc - W_LO);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_ox4   <= w_rx[61:46];
            r_oy4   <= w_ry[61:46];
            r_ss4   <= w_rs[61:46] + 16'd16384;
            r_p30_4 <= r_pr[47:15];
            r_sub4  <= r_vel_en ? 28'(w_dw * K_VEL) : '0;
        end
    end

    // stage 5: velocity factor, Q1.30
    logic [15:0] r_ox5, r_oy5, r_ss5;
    logic [32:0] r_p30_5;
    logic [30:0] r_vf5;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_ox5   <= r_ox4;
            r_oy5   <= r_oy4;
            r_ss5   <= r_ss4;
            r_p30_5 <= r_p30_4;
            r_vf5   <= (31'd1 << 30) - 31'(r_sub4);
        end
    end

    // stage 6: pressure times velocity
    logic [63:0] w_pv;
    logic [15:0] r_ox6, r_oy6, r_ss6;
    logic [32:0] r_pv6;

    assign w_pv = 64'(r_p30_5) * 64'(r_vf5);

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_ox6 <= r_ox5;
            r_oy6 <= r_oy5;
            r_ss6 <= r_ss5;
            r_pv6 <= w_pv[62:30];
        end
    end

    // stage 7: alpha, output register
    logic [37:0] w_t15;
    logic [7:0]  w_t;
    logic [15:0] r_ox7, r_oy7, r_ss7;
    logic [7:0]  r_alpha7;

    always_comb begin
        w_t15 = {1'b0, r_pv6, 4'b0} - 38'(r_pv6);
        w_t   = w_t15[37:30];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_ox7    <= r_ox6;
            r_oy7    <= r_oy6;
            r_ss7    <= r_ss6;
            r_alpha7 <= (w_t > 8'd15) ? 8'd255 : 8'd240 + w_t;
        end
    end

    assign m_axis_tvalid = r_v[STAGES-1];
    assign m_axis_tdata  = {r_alpha7, r_ss7, r_oy7, r_ox7};

    // checks
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[55:48] >= 8'd240))
        else $error("alpha below 240");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v[0])
        else $error("accepted beat not in stage 0");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_v & $past(r_v & ~w_en_up)) == $past(r_v & ~w_en_up)))
        else $error("stalled stage lost its beat");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v == '0) |-> s_axis_tready)
        else $error("empty pipeline not ready");

    a_vel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] |-> (r_sub4 <= 28'd193265664))
        else $error("velocity term out of range");

endmodule
